// ===== rtl/sia_pkg.sv =====
package sia_pkg;

  localparam int DataWidth = 32;
  localparam int RegBits   = 5;
  localparam int KindBits  = 5;
  localparam int ShiftBits = 5;
  localparam int LuiShift  = 16;
  localparam int DivSteps  = DataWidth;

  typedef logic [DataWidth-1:0] word_t;
  typedef logic [RegBits-1:0]   reg_t;

  typedef enum logic [KindBits-1:0] {
    OP_ADD    = 5'd0,
    OP_SUB    = 5'd1,
    OP_MUL    = 5'd2,
    OP_DIV    = 5'd3,
    OP_SLL    = 5'd4,
    OP_SRL    = 5'd5,
    OP_SRA    = 5'd6,
    OP_MOD    = 5'd7,
    OP_MIN    = 5'd8,
    OP_MAX    = 5'd9,
    OP_AND    = 5'd10,
    OP_OR     = 5'd11,
    OP_EQ     = 5'd12,
    OP_NE     = 5'd13,
    OP_GT     = 5'd14,
    OP_LT     = 5'd15,
    OP_LUI    = 5'd16,
    OP_ASSIGN = 5'd17
  } op_t;

  typedef struct packed {
    logic [KindBits-1:0] kind;
    word_t               a;
    word_t               b;
    reg_t                dest;
    logic                spec;
  } issue_t;

  typedef struct packed {
    logic [KindBits-1:0] kind;
    word_t               res;
    word_t               a;
    reg_t                dest;
    logic                spec;
    logic                neg_q;
    logic                neg_r;
    logic                dz;
  } side_t;

endpackage

// ===== rtl/sia_in_if.sv =====
interface sia_in_if;
  import sia_pkg::*;
  logic                valid;
  logic                ready;
  logic [KindBits-1:0] kind;
  logic signed [31:0]  first_operand;
  logic signed [31:0]  second_operand;
  logic [RegBits-1:0]  dest_register;
  logic                special_target;

  modport source (output valid, kind, first_operand, second_operand, dest_register,
                  special_target, input ready);
  modport sink (input valid, kind, first_operand, second_operand, dest_register,
                special_target, output ready);
endinterface

// ===== rtl/sia_out_if.sv =====
interface sia_out_if;
  import sia_pkg::*;
  logic               valid;
  logic               ready;
  logic signed [31:0] write_value;
  logic [RegBits-1:0] write_register;
  logic               write_special;
  logic               divide_by_zero;

  modport source (output valid, write_value, write_register, write_special, divide_by_zero,
                  input ready);
  modport sink (input valid, write_value, write_register, write_special, divide_by_zero,
                output ready);
endinterface

// ===== rtl/sia_alu.sv =====
module sia_alu (
  input  sia_pkg::issue_t iss,
  output sia_pkg::side_t  side
);
  import sia_pkg::*;

  logic [ShiftBits-1:0] sh;
  logic                 lt;
  logic                 gt;
  logic [2*DataWidth-1:0] prod;

  assign sh   = iss.b[ShiftBits-1:0];
  assign lt   = $signed(iss.a) < $signed(iss.b);
  assign gt   = $signed(iss.b) < $signed(iss.a);
  assign prod = iss.a * iss.b;

  always_comb begin
    side.kind  = iss.kind;
    side.a     = iss.a;
    side.dest  = iss.dest;
    side.spec  = 1'b0;
    side.neg_q = iss.a[DataWidth-1] ^ iss.b[DataWidth-1];
    side.neg_r = iss.a[DataWidth-1];
    side.dz    = ((iss.kind == OP_DIV) || (iss.kind == OP_MOD)) && (iss.b == '0);
    side.res   = '0;
    case (iss.kind)
      OP_ADD:    side.res = iss.a + iss.b;
      OP_SUB:    side.res = iss.a - iss.b;
      OP_MUL:    side.res = prod[DataWidth-1:0];
      OP_SLL:    side.res = iss.a << sh;
      OP_SRL:    side.res = iss.a >> sh;
      OP_SRA:    side.res = word_t'($signed(iss.a) >>> sh);
      OP_MIN:    side.res = lt ? iss.a : iss.b;
      OP_MAX:    side.res = lt ? iss.b : iss.a;
      OP_AND:    side.res = iss.a & iss.b;
      OP_OR:     side.res = iss.a | iss.b;
      OP_EQ:     side.res = word_t'(iss.a == iss.b);
      OP_NE:     side.res = word_t'(iss.a != iss.b);
      OP_GT:     side.res = word_t'(gt);
      OP_LT:     side.res = word_t'(lt);
      OP_LUI:    side.res = iss.b << LuiShift;
      OP_ASSIGN: begin
        side.res  = iss.a;
        side.spec = iss.spec;
      end
      default:   side.res = '0;
    endcase
  end
endmodule

// ===== rtl/sia_div.sv =====
module sia_div (
  input  logic          clk,
  input  logic          en,
  input  sia_pkg::word_t dividend,
  input  sia_pkg::word_t divisor,
  output sia_pkg::word_t quotient,
  output sia_pkg::word_t remainder
);
  import sia_pkg::*;

  word_t rem_r [DivSteps];
  word_t dq_r  [DivSteps];
  word_t dv_r  [DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    word_t          rem_in;
    word_t          dq_in;
    word_t          dv_in;
    logic [DataWidth:0] trial;
    logic           fits;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign dq_in  = dividend;
      assign dv_in  = divisor;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign dq_in  = dq_r[k-1];
      assign dv_in  = dv_r[k-1];
    end

    assign trial = {rem_in, dq_in[DataWidth-1]};
    assign fits  = trial >= {1'b0, dv_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= fits ? word_t'(trial - {1'b0, dv_in}) : trial[DataWidth-1:0];
        dq_r[k]  <= {dq_in[DataWidth-2:0], fits};
        dv_r[k]  <= dv_in;
      end
    end
  end

  assign quotient  = dq_r[DivSteps-1];
  assign remainder = rem_r[DivSteps-1];
endmodule

// ===== rtl/scalar_integer_alu_top.sv =====
// Scalar integer ALU: one instruction item in and one register-write item out per cycle
// unless the output stalls. Items pass one issue stage, 32 stages of a one-bit-per-stage
// restoring divider and one output stage. Every opcode travels the same path, so results
// leave in issue order; a stall on the output freezes the whole pipeline.
module scalar_integer_alu_top (
  input logic      clk,
  input logic      rst_n,
  sia_in_if.sink   in_ch,
  sia_out_if.source out_ch
);
  import sia_pkg::*;

  logic   en;
  issue_t s0_r;
  logic   s0_v_r;
  side_t  side_nxt;
  side_t  side_r [DivSteps];
  logic [DivSteps-1:0] side_v_r;
  word_t  mag_a;
  word_t  mag_b;
  word_t  quo;
  word_t  rem;
  side_t  last;
  word_t  value_nxt;
  logic   out_v_r;
  word_t  value_r;
  reg_t   reg_r;
  logic   spec_r;
  logic   dz_r;
  logic [KindBits-1:0] kind_r;

  assign en          = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r   <= 1'b0;
      side_v_r <= '0;
      out_v_r  <= 1'b0;
    end else if (en) begin
      s0_v_r   <= in_ch.valid;
      side_v_r <= {side_v_r[DivSteps-2:0], s0_v_r};
      out_v_r  <= side_v_r[DivSteps-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r.kind <= in_ch.kind;
      s0_r.a    <= word_t'(in_ch.first_operand);
      s0_r.b    <= word_t'(in_ch.second_operand);
      s0_r.dest <= in_ch.dest_register;
      s0_r.spec <= in_ch.special_target;
    end
  end

  sia_alu u_alu (
    .iss  (s0_r),
    .side (side_nxt)
  );

  assign mag_a = s0_r.a[DataWidth-1] ? word_t'(-s0_r.a) : s0_r.a;
  assign mag_b = s0_r.b[DataWidth-1] ? word_t'(-s0_r.b) : s0_r.b;

  sia_div u_div (
    .clk       (clk),
    .en        (en),
    .dividend  (mag_a),
    .divisor   (mag_b),
    .quotient  (quo),
    .remainder (rem)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      for (int k = 1; k < DivSteps; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign last = side_r[DivSteps-1];

  always_comb begin
    value_nxt = last.res;
    case (last.kind)
      OP_DIV: begin
        if (last.dz) begin
          value_nxt = '1;
        end else begin
          value_nxt = last.neg_q ? word_t'(-quo) : quo;
        end
      end
      OP_MOD: begin
        if (last.dz) begin
          value_nxt = last.a;
        end else begin
          value_nxt = last.neg_r ? word_t'(-rem) : rem;
        end
      end
      default: value_nxt = last.res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value_r <= value_nxt;
      reg_r   <= last.dest;
      spec_r  <= last.spec;
      dz_r    <= last.dz;
      kind_r  <= last.kind;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.write_value    = $signed(value_r);
  assign out_ch.write_register = reg_r;
  assign out_ch.write_special  = spec_r;
  assign out_ch.divide_by_zero = dz_r;

`ifndef NO_ASSERTIONS
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");
  a_dz_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.divide_by_zero |-> (kind_r == OP_DIV) || (kind_r == OP_MOD))
    else $error("divide by zero on non-divide item");
  a_spec_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.write_special |-> kind_r == OP_ASSIGN)
    else $error("special write on non-assign item");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> out_v_r && $stable(side_v_r))
    else $error("pipeline moved during stall");
`endif
endmodule
